>>> hw/rtl/cyclic_frame_task_scheduler_defines.svh
// assertion macros for the frame scheduler checker
`ifndef CYCLIC_FRAME_TASK_SCHEDULER_DEFINES_SVH
`define CYCLIC_FRAME_TASK_SCHEDULER_DEFINES_SVH

// same-cycle implication on clock, disabled in reset
`define CFTS_IMPLIES(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |-> (c)) \
      else $error("cfts check failed");

// next-cycle implication on clock, disabled in reset
`define CFTS_NEXT(lbl, a, c) \
   lbl: assert property (@(posedge clock) disable iff (reset) (a) |=> (c)) \
      else $error("cfts check failed");

`endif

>>> hw/rtl/cfts_pkg.sv
// types and constants shared by the frame scheduler files
`default_nettype none
package cfts_pkg;

   localparam int MaxTasks = 16;
   localparam int TaskIdxW = $clog2(MaxTasks);
   localparam int AddrW = 4;
   localparam logic [31:0] FrameTicksReset = 32'd1000;

   typedef enum logic [2:0] {
      KIND_SET      = 3'd0,
      KIND_OPEN     = 3'd1,
      KIND_DISPATCH = 3'd2,
      KIND_REPORT   = 3'd3,
      KIND_CHECK    = 3'd4,
      KIND_ADVANCE  = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      ST_OK        = 2'd0,
      ST_BAD_COUNT = 2'd1,
      ST_UNSTABLE  = 2'd2,
      ST_COMPLETE  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      REG_TASK_COUNT    = 2'd0,
      REG_FRAME_TICKS   = 2'd1,
      REG_WINDOW_FRAMES = 2'd2,
      REG_BOOT_SAFE     = 2'd3
   } reg_type;

   typedef enum logic [2:0] {
      S_IDLE,
      S_EXEC,
      S_WK_ADDR,
      S_WK_DATA,
      S_WK_DIV,
      S_WK_END
   } state_type;

   typedef struct packed {
      logic [15:0] period;
      logic        essential;
      logic        present;
      logic [31:0] budget;
   } task_entry_type;

   typedef struct packed {
      logic [31:0] runs;
      logic [31:0] max_used;
      logic [31:0] overruns;
   } stat_type;

   typedef struct packed {
      logic [2:0]  kind;
      logic [3:0]  task_index;
      logic [15:0] period;
      logic        essential;
      logic        present;
      logic [31:0] budget;
      logic [31:0] used;
      logic [63:0] now;
      logic        clock_unstable;
   } req_word_type;

   typedef struct packed {
      status_type  status;
      logic [3:0]  due_task;
      logic        task_valid;
      logic        last;
      logic        safe_mode;
      logic        frame_overrun;
      logic [31:0] slack;
      logic [31:0] slack_min;
      logic [31:0] frame_number;
      logic [31:0] task_runs;
      logic [31:0] task_max_used;
      logic [31:0] task_overruns;
   } rsp_word_type;

   typedef struct packed {
      logic        busy;
      logic [15:0] rem;
   } rem_status_type;

endpackage
`default_nettype wire

>>> hw/rtl/cfts_if.sv
// request and response channel interfaces of the frame scheduler
`default_nettype none
interface cfts_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  task_index;
   logic [15:0] period;
   logic        essential;
   logic        present;
   logic [31:0] budget;
   logic [31:0] used;
   logic [63:0] now;
   logic        clock_unstable;

   modport source (output valid, kind, task_index, period, essential, present, budget,
                   used, now, clock_unstable, input ready);
   modport sink (input valid, kind, task_index, period, essential, present, budget,
                 used, now, clock_unstable, output ready);
endinterface

interface cfts_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  status;
   logic [3:0]  due_task;
   logic        task_valid;
   logic        last;
   logic        safe_mode;
   logic        frame_overrun;
   logic [31:0] slack;
   logic [31:0] slack_min;
   logic [31:0] frame_number;
   logic [31:0] task_runs;
   logic [31:0] task_max_used;
   logic [31:0] task_overruns;

   modport source (output valid, status, due_task, task_valid, last, safe_mode,
                   frame_overrun, slack, slack_min, frame_number, task_runs,
                   task_max_used, task_overruns, input ready);
   modport sink (input valid, status, due_task, task_valid, last, safe_mode,
                 frame_overrun, slack, slack_min, frame_number, task_runs,
                 task_max_used, task_overruns, output ready);
endinterface
`default_nettype wire

>>> hw/rtl/cfts_rem.sv
// bit-serial remainder unit: 32-bit frame number modulo 16-bit period
`default_nettype none
module cfts_rem (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire logic                       start,
   input  wire logic [31:0]                dividend,
   input  wire logic [15:0]                divisor,
   output cfts_pkg::rem_status_type        rs
);

   logic        busy_ff, busy_in;
   logic [4:0]  cnt_ff, cnt_in;
   logic [31:0] quo_ff, quo_in;
   logic [15:0] rem_ff, rem_in;
   logic [15:0] div_ff, div_in;
   logic [16:0] shifted;
   logic [16:0] diff;

   always_comb begin
      shifted = {rem_ff, quo_ff[31]};
      diff = shifted - {1'b0, div_ff};
      busy_in = busy_ff;
      cnt_in = cnt_ff;
      quo_in = quo_ff;
      rem_in = rem_ff;
      div_in = div_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in = '0;
         quo_in = dividend;
         rem_in = '0;
         div_in = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[30:0], 1'b0};
         rem_in = (shifted >= {1'b0, div_ff}) ? diff[15:0] : shifted[15:0];
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign rs.busy = busy_ff;
   assign rs.rem = rem_ff;

endmodule
`default_nettype wire

>>> hw/rtl/cyclic_frame_task_scheduler.sv
// top level of the cyclic frame task scheduler
//
// channel   dir  handshake           word
// req_ch    in   valid/ready         event kind and its fields
// rsp_ch    out  valid/ready         one result; a dispatch gives one per due task, at least one
// apb       in   psel/penable/pready four registers at byte address 4*i
//
// one item at a time; for all kinds but dispatch the request is registered, then
// the result is registered. a dispatch walks task_count table entries through the
// address and data states, running the serial remainder unit on each that may run.
// synchronous active-high reset; the table holds garbage until written.
// a stalled response holds the walk; the request side waits while busy.
`default_nettype none
module cyclic_frame_task_scheduler (
   input  wire logic                     clock,
   input  wire logic                     reset,
   cfts_req_if.sink                      req_ch,
   cfts_rsp_if.source                    rsp_ch,
   input  wire logic                     psel,
   input  wire logic                     penable,
   input  wire logic                     pwrite,
   input  wire logic [cfts_pkg::AddrW-1:0] paddr,
   input  wire logic [31:0]              pwdata,
   output logic [31:0]                   prdata,
   output logic                          pready
);

   cfts_pkg::state_type       state_ff, state_in;
   cfts_pkg::req_word_type    in_ff, in_in;
   cfts_pkg::rsp_word_type    out_ff, out_in;
   logic                      out_valid_ff, out_valid_in;
   logic                      out_load;
   logic                      out_free;

   logic [4:0]                task_count_ff;
   logic [31:0]               frame_ticks_ff;
   logic [31:0]               window_frames_ff;
   logic                      boot_safe_ff;

   logic [31:0]               fc_ff, fc_in;
   logic [63:0]               start_ff, start_in;
   logic [63:0]               deadline_ff;
   logic [31:0]               min_slack_ff, min_slack_in;
   logic                      safe_ff, safe_in;

   cfts_pkg::task_entry_type  tbl_mem [cfts_pkg::MaxTasks];
   cfts_pkg::task_entry_type  tbl_q_ff;
   logic [cfts_pkg::TaskIdxW-1:0] tbl_raddr;
   logic                      tbl_we;

   cfts_pkg::stat_type        stat_mem [cfts_pkg::MaxTasks];
   cfts_pkg::stat_type        stat_q_ff;
   logic                      stat_rvld_ff;
   logic [cfts_pkg::MaxTasks-1:0] stat_vld_ff;
   logic                      stat_we;
   cfts_pkg::stat_type        stat_wdata;
   cfts_pkg::stat_type        stat_cur;

   logic [cfts_pkg::TaskIdxW-1:0] wi_ff, wi_in;
   logic [cfts_pkg::TaskIdxW-1:0] last_idx;
   logic                      pend_valid_ff, pend_valid_in;
   logic [cfts_pkg::TaskIdxW-1:0] pend_idx_ff, pend_idx_in;

   logic                      rem_start;
   cfts_pkg::rem_status_type  rem_st;

   logic                      accept;
   logic                      csr_write;
   logic                      count_bad;
   logic                      eligible;
   logic                      late;
   logic [63:0]               gap;
   logic [31:0]               gap_sat;
   logic [31:0]               fc_step;

   cfts_rem u_rem (
      .clock    (clock),
      .reset    (reset),
      .start    (rem_start),
      .dividend (fc_ff),
      .divisor  (tbl_q_ff.period),
      .rs       (rem_st)
   );

   assign out_free = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = (state_ff == cfts_pkg::S_IDLE) && out_free;
   assign accept = req_ch.valid && req_ch.ready;
   assign csr_write = psel && penable && pwrite;
   assign pready = 1'b1;
   assign count_bad = (task_count_ff == 5'd0) ||
                      (task_count_ff > 5'(cfts_pkg::MaxTasks));
   assign last_idx = cfts_pkg::TaskIdxW'(task_count_ff - 5'd1);
   assign stat_cur = stat_rvld_ff ? stat_q_ff : '0;
   assign eligible = tbl_q_ff.present && (tbl_q_ff.period != 16'd0) &&
                     (!safe_ff || tbl_q_ff.essential);
   assign late = in_ff.now >= deadline_ff;
   assign gap = deadline_ff - in_ff.now;
   assign gap_sat = (|gap[63:32]) ? 32'hFFFF_FFFF : gap[31:0];
   assign fc_step = fc_ff + 32'd1;

   always_comb begin
      case (cfts_pkg::reg_type'(paddr[3:2]))
         cfts_pkg::REG_TASK_COUNT:    prdata = {27'd0, task_count_ff};
         cfts_pkg::REG_FRAME_TICKS:   prdata = frame_ticks_ff;
         cfts_pkg::REG_WINDOW_FRAMES: prdata = window_frames_ff;
         cfts_pkg::REG_BOOT_SAFE:     prdata = {31'd0, boot_safe_ff};
         default:                     prdata = '0;
      endcase
   end

   always_comb begin
      state_in = state_ff;
      in_in = in_ff;
      out_load = 1'b0;
      out_in = out_ff;
      fc_in = fc_ff;
      start_in = start_ff;
      min_slack_in = min_slack_ff;
      safe_in = safe_ff;
      tbl_raddr = req_ch.task_index;
      tbl_we = 1'b0;
      stat_we = 1'b0;
      stat_wdata = stat_cur;
      wi_in = wi_ff;
      pend_valid_in = pend_valid_ff;
      pend_idx_in = pend_idx_ff;
      rem_start = 1'b0;

      case (state_ff)
         cfts_pkg::S_IDLE: begin
            if (accept) begin
               in_in.kind = req_ch.kind;
               in_in.task_index = req_ch.task_index;
               in_in.period = req_ch.period;
               in_in.essential = req_ch.essential;
               in_in.present = req_ch.present;
               in_in.budget = req_ch.budget;
               in_in.used = req_ch.used;
               in_in.now = req_ch.now;
               in_in.clock_unstable = req_ch.clock_unstable;
               state_in = cfts_pkg::S_EXEC;
            end
         end
         cfts_pkg::S_EXEC: begin
            out_load = 1'b1;
            out_in = '0;
            out_in.status = cfts_pkg::ST_OK;
            out_in.last = 1'b1;
            state_in = cfts_pkg::S_IDLE;
            case (in_ff.kind)
               cfts_pkg::KIND_SET: begin
                  tbl_we = 1'b1;
               end
               cfts_pkg::KIND_OPEN: begin
                  if (count_bad) begin
                     out_in.status = cfts_pkg::ST_BAD_COUNT;
                  end else begin
                     safe_in = safe_ff || boot_safe_ff || in_ff.clock_unstable;
                     if (in_ff.clock_unstable) begin
                        out_in.status = cfts_pkg::ST_UNSTABLE;
                     end else begin
                        min_slack_in = frame_ticks_ff;
                        start_in = in_ff.now;
                        fc_in = '0;
                        if (window_frames_ff == 32'd0) begin
                           out_in.status = cfts_pkg::ST_COMPLETE;
                        end
                     end
                  end
               end
               cfts_pkg::KIND_DISPATCH: begin
                  if (count_bad) begin
                     out_in.status = cfts_pkg::ST_BAD_COUNT;
                  end else begin
                     out_load = 1'b0;
                     wi_in = '0;
                     pend_valid_in = 1'b0;
                     state_in = cfts_pkg::S_WK_ADDR;
                  end
               end
               cfts_pkg::KIND_REPORT: begin
                  out_in.due_task = in_ff.task_index;
                  if (tbl_q_ff.present) begin
                     stat_we = 1'b1;
                     stat_wdata.runs = stat_cur.runs + 32'd1;
                     if (in_ff.used > stat_cur.max_used) begin
                        stat_wdata.max_used = in_ff.used;
                     end
                     if (in_ff.used > tbl_q_ff.budget) begin
                        stat_wdata.overruns = stat_cur.overruns + 32'd1;
                     end
                  end
                  out_in.task_runs = stat_wdata.runs;
                  out_in.task_max_used = stat_wdata.max_used;
                  out_in.task_overruns = stat_wdata.overruns;
               end
               cfts_pkg::KIND_CHECK: begin
                  if (in_ff.clock_unstable) begin
                     safe_in = 1'b1;
                     out_in.status = cfts_pkg::ST_UNSTABLE;
                  end else if (late) begin
                     min_slack_in = '0;
                     safe_in = 1'b1;
                     out_in.frame_overrun = 1'b1;
                  end else begin
                     if (gap_sat < min_slack_ff) begin
                        min_slack_in = gap_sat;
                     end
                     out_in.slack = gap_sat;
                  end
               end
               cfts_pkg::KIND_ADVANCE: begin
                  if (in_ff.clock_unstable) begin
                     safe_in = 1'b1;
                     out_in.status = cfts_pkg::ST_UNSTABLE;
                  end else begin
                     start_in = deadline_ff;
                     fc_in = fc_step;
                     if (fc_step >= window_frames_ff) begin
                        out_in.status = cfts_pkg::ST_COMPLETE;
                     end
                  end
               end
               default: begin
               end
            endcase
            out_in.safe_mode = safe_in;
            out_in.slack_min = min_slack_in;
            out_in.frame_number = fc_in;
         end
         cfts_pkg::S_WK_ADDR: begin
            tbl_raddr = wi_ff;
            state_in = cfts_pkg::S_WK_DATA;
         end
         cfts_pkg::S_WK_DATA: begin
            if (eligible) begin
               rem_start = 1'b1;
               state_in = cfts_pkg::S_WK_DIV;
            end else if (wi_ff == last_idx) begin
               state_in = cfts_pkg::S_WK_END;
            end else begin
               wi_in = wi_ff + 1'b1;
               state_in = cfts_pkg::S_WK_ADDR;
            end
         end
         cfts_pkg::S_WK_DIV: begin
            if (!rem_st.busy && !(rem_st.rem == 16'd0 && pend_valid_ff && !out_free)) begin
               if (rem_st.rem == 16'd0) begin
                  if (pend_valid_ff) begin
                     out_load = 1'b1;
                     out_in = '0;
                     out_in.status = cfts_pkg::ST_OK;
                     out_in.due_task = pend_idx_ff;
                     out_in.task_valid = 1'b1;
                     out_in.safe_mode = safe_ff;
                     out_in.slack_min = min_slack_ff;
                     out_in.frame_number = fc_ff;
                  end
                  pend_valid_in = 1'b1;
                  pend_idx_in = wi_ff;
               end
               if (wi_ff == last_idx) begin
                  state_in = cfts_pkg::S_WK_END;
               end else begin
                  wi_in = wi_ff + 1'b1;
                  state_in = cfts_pkg::S_WK_ADDR;
               end
            end
         end
         cfts_pkg::S_WK_END: begin
            if (out_free) begin
               out_load = 1'b1;
               out_in = '0;
               out_in.status = cfts_pkg::ST_OK;
               out_in.due_task = pend_valid_ff ? pend_idx_ff : '0;
               out_in.task_valid = pend_valid_ff;
               out_in.last = 1'b1;
               out_in.safe_mode = safe_ff;
               out_in.slack_min = min_slack_ff;
               out_in.frame_number = fc_ff;
               state_in = cfts_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = cfts_pkg::S_IDLE;
         end
      endcase

      if (out_load) begin
         out_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         out_valid_in = 1'b0;
      end else begin
         out_valid_in = out_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cfts_pkg::S_IDLE;
         out_valid_ff <= 1'b0;
         task_count_ff <= '0;
         frame_ticks_ff <= cfts_pkg::FrameTicksReset;
         window_frames_ff <= '0;
         boot_safe_ff <= 1'b0;
         fc_ff <= '0;
         start_ff <= '0;
         min_slack_ff <= '0;
         safe_ff <= 1'b0;
         stat_vld_ff <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         out_valid_ff <= out_valid_in;
         fc_ff <= fc_in;
         start_ff <= start_in;
         min_slack_ff <= min_slack_in;
         safe_ff <= safe_in;
         pend_valid_ff <= pend_valid_in;
         if (stat_we) begin
            stat_vld_ff[in_ff.task_index] <= 1'b1;
         end
         if (csr_write) begin
            case (cfts_pkg::reg_type'(paddr[3:2]))
               cfts_pkg::REG_TASK_COUNT:    task_count_ff <= pwdata[4:0];
               cfts_pkg::REG_FRAME_TICKS:   frame_ticks_ff <= pwdata;
               cfts_pkg::REG_WINDOW_FRAMES: window_frames_ff <= pwdata;
               cfts_pkg::REG_BOOT_SAFE:     boot_safe_ff <= pwdata[0];
               default: begin
               end
            endcase
         end
      end
      in_ff <= in_in;
      out_ff <= out_in;
      wi_ff <= wi_in;
      pend_idx_ff <= pend_idx_in;
      deadline_ff <= start_ff + {32'd0, frame_ticks_ff};
      stat_rvld_ff <= stat_vld_ff[req_ch.task_index];
   end

   always_ff @(posedge clock) begin
      if (tbl_we) begin
         tbl_mem[in_ff.task_index] <= {in_ff.period, in_ff.essential, in_ff.present,
                                       in_ff.budget};
      end
      tbl_q_ff <= tbl_mem[tbl_raddr];
   end

   always_ff @(posedge clock) begin
      if (stat_we) begin
         stat_mem[in_ff.task_index] <= stat_wdata;
      end
      stat_q_ff <= stat_mem[req_ch.task_index];
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.status = out_ff.status;
   assign rsp_ch.due_task = out_ff.due_task;
   assign rsp_ch.task_valid = out_ff.task_valid;
   assign rsp_ch.last = out_ff.last;
   assign rsp_ch.safe_mode = out_ff.safe_mode;
   assign rsp_ch.frame_overrun = out_ff.frame_overrun;
   assign rsp_ch.slack = out_ff.slack;
   assign rsp_ch.slack_min = out_ff.slack_min;
   assign rsp_ch.frame_number = out_ff.frame_number;
   assign rsp_ch.task_runs = out_ff.task_runs;
   assign rsp_ch.task_max_used = out_ff.task_max_used;
   assign rsp_ch.task_overruns = out_ff.task_overruns;

endmodule
`default_nettype wire

>>> hw/rtl/cfts_checker.sv
// port-level checks on the frame scheduler, bound to the top level
`default_nettype none
`include "cyclic_frame_task_scheduler_defines.svh"
module cfts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [1:0]  rsp_status,
   input wire logic        rsp_task_valid,
   input wire logic        rsp_last,
   input wire logic        rsp_safe,
   input wire logic        rsp_overrun,
   input wire logic [31:0] rsp_slack
);

   `CFTS_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid)
   `CFTS_IMPLIES(a_task_ok, rsp_valid && rsp_task_valid, rsp_status == cfts_pkg::ST_OK)
   `CFTS_IMPLIES(a_overrun_safe, rsp_valid && rsp_overrun, rsp_safe && rsp_slack == 32'd0)
   `CFTS_IMPLIES(a_bad_single, rsp_valid && rsp_status == cfts_pkg::ST_BAD_COUNT, rsp_last && !rsp_task_valid)

endmodule

bind cyclic_frame_task_scheduler cfts_checker u_cfts_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_status     (rsp_ch.status),
   .rsp_task_valid (rsp_ch.task_valid),
   .rsp_last       (rsp_ch.last),
   .rsp_safe       (rsp_ch.safe_mode),
   .rsp_overrun    (rsp_ch.frame_overrun),
   .rsp_slack      (rsp_ch.slack)
);
`default_nettype wire
